/* rtl/lri_pkg.sv */
// Shared types and constants of the linear interpolation resampler.
// No dependencies; imported by the controller, merge stage and top level.
package lri_pkg;

	localparam int STEP_W = 21;
	localparam int CHAN_W = 2;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(2048);
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
	localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);
	localparam logic [CHAN_W-1:0] CHAN_MONO  = CHAN_W'(1);

	typedef enum logic {
		REG_STEP_RATIO    = 1'b0,
		REG_CHANNEL_COUNT = 1'b1
	} lri_reg_t;

	typedef struct packed {
		logic valid;
		logic run_end;
		logic stereo;
	} lri_issue_t;

endpackage

/* rtl/lri_in_if.sv */
// Input stream channel of the resampler: one frame of samples per item.
// Standalone; used by the controller and the top level.
interface lri_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_ch0;
	logic signed [SAMPLE_BITS-1:0] sample_ch1;
	logic                          last_frame;

	modport source (output valid, output sample_ch0, output sample_ch1, output last_frame,
		input ready);
	modport sink (input valid, input sample_ch0, input sample_ch1, input last_frame,
		output ready);
endinterface

/* rtl/lri_out_if.sv */
// Output stream channel of the resampler: one interpolated frame per item.
// Standalone; used by the merge stage and the top level.
interface lri_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_ch0;
	logic signed [SAMPLE_BITS-1:0] out_ch1;
	logic                          run_end;

	modport source (output valid, output out_ch0, output out_ch1, output run_end,
		input ready);
	modport sink (input valid, input out_ch0, input out_ch1, input run_end,
		output ready);
endinterface

/* rtl/lri_lane.sv */
// One interpolation lane: registered frac*(target-base), then round and saturate.
// Standalone; instantiated once per channel by the top level.
module lri_lane #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] base,
	input  logic signed [SAMPLE_BITS-1:0] target,
	input  logic        [FRAC_BITS-1:0]   frac,
	output logic signed [SAMPLE_BITS-1:0] result
);
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int ACC_W  = SAMPLE_BITS + FRAC_BITS + 3;
	localparam int RND_W  = SAMPLE_BITS + 3;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [RND_W-1:0] SMAX = $signed({4'b0000, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [RND_W-1:0] SMIN = $signed({4'b1111, {(SAMPLE_BITS-1){1'b0}}});

	logic signed [DIFF_W-1:0]      diff;
	logic signed [PROD_W-1:0]      prod_s1;
	logic signed [SAMPLE_BITS-1:0] base_s1;
	logic signed [ACC_W-1:0]       acc;
	logic signed [RND_W-1:0]       rnd;

	assign diff = DIFF_W'(target) - DIFF_W'(base);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= $signed({1'b0, frac}) * diff;
			base_s1 <= base;
		end
	end

	always_comb begin
		acc = (ACC_W'(base_s1) <<< FRAC_BITS) + ACC_W'(prod_s1) + HALF;
		rnd = $signed(acc[ACC_W-1:FRAC_BITS]);
		if (rnd > SMAX) begin
			result = SMAX[SAMPLE_BITS-1:0];
		end else if (rnd < SMIN) begin
			result = SMIN[SAMPLE_BITS-1:0];
		end else begin
			result = rnd[SAMPLE_BITS-1:0];
		end
	end
endmodule

/* rtl/lri_ctrl.sv */
// Sequencer: holds previous and current frame and the phase accumulator,
// issues one output position per cycle to the lanes while en is high. Depends on lri_pkg, lri_in_if.
module lri_ctrl #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [lri_pkg::STEP_W-1:0]    step_ratio,
	input  logic                          stereo,
	lri_in_if.sink                        in_item,
	output lri_pkg::lri_issue_t           issue,
	output logic signed [SAMPLE_BITS-1:0] base [2],
	output logic signed [SAMPLE_BITS-1:0] target [2],
	output logic        [FRAC_BITS-1:0]   frac
);
	import lri_pkg::*;

	localparam int PH_W = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 2;
	localparam logic [PH_W-1:0] ONE = PH_W'(1) << FRAC_BITS;
	localparam logic [PH_W-1:0] TWO = PH_W'(1) << (FRAC_BITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LERP,
		ST_HOLD
	} state_t;

	state_t                        state_q;
	logic [PH_W-1:0]               phase_q;
	logic                          have_prev_q;
	logic                          last_q;
	logic signed [SAMPLE_BITS-1:0] prev_q [2];
	logic signed [SAMPLE_BITS-1:0] cur_q [2];

	logic [STEP_W-1:0] step_eff;
	logic [PH_W-1:0]   nxt;
	logic              below;

	assign step_eff = (step_ratio < STEP_MIN) ? STEP_MIN : step_ratio;
	assign nxt      = phase_q + PH_W'(step_eff);
	assign below    = phase_q < ONE;
	assign in_item.ready = (state_q == ST_IDLE);

	always_comb begin
		issue.valid   = 1'b0;
		issue.run_end = 1'b0;
		issue.stereo  = stereo;
		base          = prev_q;
		target        = cur_q;
		frac          = phase_q[FRAC_BITS-1:0];
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_LERP: begin
				issue.valid   = below;
				issue.run_end = (nxt >= ONE) && (!last_q || nxt >= TWO);
			end
			ST_HOLD: begin
				issue.valid   = below;
				issue.run_end = nxt >= ONE;
				base          = cur_q;
				frac          = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			have_prev_q <= 1'b0;
			last_q      <= 1'b0;
			prev_q[0]   <= '0;
			prev_q[1]   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_item.valid) begin
						last_q <= in_item.last_frame;
						if (have_prev_q) begin
							state_q <= ST_LERP;
						end else begin
							phase_q <= '0;
							if (in_item.last_frame) begin
								state_q <= ST_HOLD;
							end else begin
								have_prev_q <= 1'b1;
								prev_q[0]   <= in_item.sample_ch0;
								prev_q[1]   <= stereo ? in_item.sample_ch1 : '0;
							end
						end
					end
				end
				ST_LERP: begin
					if (en) begin
						if (below) begin
							phase_q <= nxt;
						end else begin
							phase_q <= phase_q - ONE;
							if (last_q) begin
								state_q <= ST_HOLD;
							end else begin
								prev_q[0] <= cur_q[0];
								prev_q[1] <= stereo ? cur_q[1] : '0;
								state_q   <= ST_IDLE;
							end
						end
					end
				end
				ST_HOLD: begin
					if (en) begin
						if (below) begin
							phase_q <= nxt;
						end else begin
							phase_q     <= '0;
							have_prev_q <= 1'b0;
							prev_q[0]   <= '0;
							prev_q[1]   <= '0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			cur_q[0] <= in_item.sample_ch0;
			cur_q[1] <= in_item.sample_ch1;
		end
	end
endmodule

/* rtl/lri_merge.sv */
// Merge stage: carries the issue tags alongside the lanes, combines lane
// results into one output item and holds it until taken. Depends on lri_pkg, lri_out_if.
module lri_merge #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lri_pkg::lri_issue_t           issue,
	input  logic signed [SAMPLE_BITS-1:0] lane_res [2],
	output logic                          en,
	lri_out_if.source                     out_item
);
	import lri_pkg::*;

	lri_issue_t                    info_s1;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] ch0_q;
	logic signed [SAMPLE_BITS-1:0] ch1_q;
	logic                          run_end_q;

	assign en = !out_valid_q || out_item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_s1     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			info_s1     <= issue;
			out_valid_q <= info_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && info_s1.valid) begin
			ch0_q     <= lane_res[0];
			ch1_q     <= info_s1.stereo ? lane_res[1] : '0;
			run_end_q <= info_s1.run_end;
		end
	end

	assign out_item.valid   = out_valid_q;
	assign out_item.out_ch0 = ch0_q;
	assign out_item.out_ch1 = ch1_q;
	assign out_item.run_end = run_end_q;
endmodule

/* rtl/linear_interp_resampler_core.sv */
// Top level of the linear interpolation resampler: register port, sequencer,
// channel lanes and merge stage. Depends on lri_pkg, lri_in_if, lri_out_if and all lri_ modules.
//
//   port      | dir | kind          | carries
//   ----------+-----+---------------+---------------------------------------
//   in_item   | in  | valid/ready   | sample_ch0, sample_ch1, last_frame
//   out_item  | out | valid/ready   | out_ch0, out_ch1, run_end
//   APB       | in  | psel/penable  | step_ratio (0x0), channel_count (0x4)
//
// A frame is taken, then one output item is issued per cycle from the phase accumulator
// while no output item is held, plus a closing step for each interval; a final frame
// after another also runs a hold interval on its own samples, and a frame that opens
// a stream and is not final is only stored. Results pass the lane and merge registers.
// A held output item stalls issue and the lanes together.
// Reset clears the registers to their defaults and the stream state to empty.
module linear_interp_resampler_core #(
	parameter int LANES       = 2,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lri_in_if.sink                       in_item,
	lri_out_if.source                    out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lri_pkg::APB_AW-1:0]   paddr,
	input  logic [lri_pkg::APB_DW-1:0]   pwdata,
	output logic [lri_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import lri_pkg::*;

	logic [STEP_W-1:0]             step_ratio_q;
	logic [CHAN_W-1:0]             channel_count_q;
	logic                          stereo;
	logic                          en;
	lri_issue_t                    issue;
	logic signed [SAMPLE_BITS-1:0] base [2];
	logic signed [SAMPLE_BITS-1:0] target [2];
	logic        [FRAC_BITS-1:0]   frac;
	logic signed [SAMPLE_BITS-1:0] lane_res [2];
	lri_reg_t                      reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = lri_reg_t'(paddr[2]);
	assign stereo  = (channel_count_q != CHAN_MONO) && (LANES >= 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_ratio_q    <= STEP_RESET;
			channel_count_q <= CHAN_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_STEP_RATIO:    step_ratio_q    <= pwdata[STEP_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= pwdata[CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_STEP_RATIO:    prdata = APB_DW'(step_ratio_q);
			REG_CHANNEL_COUNT: prdata = APB_DW'(channel_count_q);
			default:           prdata = '0;
		endcase
	end

	lri_ctrl #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.step_ratio(step_ratio_q),
		.stereo    (stereo),
		.in_item   (in_item),
		.issue     (issue),
		.base      (base),
		.target    (target),
		.frac      (frac)
	);

	lri_lane #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_lane0 (
		.clk   (clk),
		.en    (en),
		.base  (base[0]),
		.target(target[0]),
		.frac  (frac),
		.result(lane_res[0])
	);

	if (LANES >= 2) begin : g_lane1
		lri_lane #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.FRAC_BITS  (FRAC_BITS)
		) u_lane1 (
			.clk   (clk),
			.en    (en),
			.base  (base[1]),
			.target(target[1]),
			.frac  (frac),
			.result(lane_res[1])
		);
	end else begin : g_no_lane1
		assign lane_res[1] = '0;
	end

	lri_merge #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.lane_res(lane_res),
		.en      (en),
		.out_item(out_item)
	);

`ifndef SYNTHESIS
	a_no_take_while_issuing: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> !in_item.ready)
		else $error("item accepted while outputs still being issued");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_item.valid && in_item.ready && in_item.last_frame) |=> !in_item.ready)
		else $error("final frame left no work in the sequencer");

	a_mono_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_item.valid && !stereo) |-> (out_item.out_ch1 == '0))
		else $error("second channel not cleared in mono");
`endif
endmodule

/* dv/testbench.sv */
// Self-checking testbench of linear_interp_resampler_core: drives frames and APB writes,
// predicts every interpolated output item and checks each one against the block.
// Depends on lri_pkg, lri_in_if, lri_out_if and the resampler RTL.
`timescale 1ns / 100ps

module testbench;
	import lri_pkg::*;

	localparam logic [23:0] ONE_PHASE = 24'h010000;
	localparam int MAX_RESULTS   = 64;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PHASES = 12;
	localparam int RANDOM_ITEMS  = 35;
	localparam int PRESSURE_PHASE = 2;

	typedef struct packed {
		logic signed [15:0] ch0;
		logic signed [15:0] ch1;
		logic               run_end;
	} interp_out_t;

	class resample_tracker_t;
		logic [STEP_W-1:0] step_reg;
		logic [CHAN_W-1:0] chan_reg;
		logic signed [15:0] prev0;
		logic signed [15:0] prev1;
		logic [23:0] phase;
		bit have_prev;
		interp_out_t expected_outputs[$];
		int failures;

		function new();
			step_reg  = STEP_RESET;
			chan_reg  = CHAN_RESET;
			prev0     = '0;
			prev1     = '0;
			phase     = '0;
			have_prev = 1'b0;
			failures  = 0;
		endfunction

		function void set_reg(lri_reg_t idx, logic [31:0] value);
			if (idx == REG_STEP_RATIO)
				step_reg = value[STEP_W-1:0];
			else
				chan_reg = value[CHAN_W-1:0];
		endfunction

		function int pending();
			return expected_outputs.size();
		endfunction

		function logic signed [15:0] lerp(logic signed [15:0] a, logic signed [15:0] b,
			logic [15:0] frac);
			longint acc;
			acc = longint'(a) * 65536 + longint'(frac) * (longint'(b) - longint'(a)) + 32768;
			acc = acc >>> 16;
			if (acc > 32767)
				acc = 32767;
			if (acc < -32768)
				acc = -32768;
			return 16'(acc);
		endfunction

		function void queue_output(logic signed [15:0] c0, logic signed [15:0] c1, bit stereo);
			interp_out_t r;
			r.ch0     = c0;
			r.ch1     = stereo ? c1 : 16'sd0;
			r.run_end = 1'b0;
			expected_outputs.push_back(r);
		endfunction

		function void take_frame(logic signed [15:0] cur0, logic signed [15:0] cur1, logic last);
			logic [STEP_W-1:0] inc;
			bit stereo;
			int n;
			interp_out_t r;
			inc    = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;
			stereo = (chan_reg != CHAN_MONO);
			n      = 0;
			if (have_prev) begin
				while (phase < ONE_PHASE && n < MAX_RESULTS) begin
					queue_output(lerp(prev0, cur0, phase[15:0]), lerp(prev1, cur1, phase[15:0]),
						stereo);
					n++;
					phase = phase + 24'(inc);
				end
				phase = (phase >= ONE_PHASE) ? phase - ONE_PHASE : 24'd0;
			end else begin
				phase     = '0;
				have_prev = 1'b1;
			end
			if (last) begin
				while (phase < ONE_PHASE && n < MAX_RESULTS) begin
					queue_output(cur0, cur1, stereo);
					n++;
					phase = phase + 24'(inc);
				end
				prev0     = '0;
				prev1     = '0;
				phase     = '0;
				have_prev = 1'b0;
			end else begin
				prev0 = cur0;
				prev1 = stereo ? cur1 : 16'sd0;
			end
			if (n > 0) begin
				r = expected_outputs.pop_back();
				r.run_end = 1'b1;
				expected_outputs.push_back(r);
			end
		endfunction

		function void match_output(logic signed [15:0] o0, logic signed [15:0] o1, logic re);
			interp_out_t r;
			if (expected_outputs.size() == 0) begin
				$display("%0t: unexpected output item ch0 %h ch1 %h run_end %b",
					$time, o0, o1, re);
				failures++;
				return;
			end
			r = expected_outputs.pop_front();
			if (r.ch0 !== o0) begin
				$display("%0t: out_ch0 expected %h actual %h", $time, r.ch0, o0);
				failures++;
			end
			if (r.ch1 !== o1) begin
				$display("%0t: out_ch1 expected %h actual %h", $time, r.ch1, o1);
				failures++;
			end
			if (r.run_end !== re) begin
				$display("%0t: run_end expected %b actual %b", $time, r.run_end, re);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	lri_in_if #(.SAMPLE_BITS(16)) in_bus ();
	lri_out_if #(.SAMPLE_BITS(16)) out_bus ();

	resample_tracker_t tracker = new();

	bit pressure_armed = 1'b0;
	bit gaps_on = 1'b1;
	int burst_left = 0;

	linear_interp_resampler_core #(
		.LANES(2),
		.SAMPLE_BITS(16),
		.FRAC_BITS(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_bus),
		.out_item(out_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	task automatic write_reg(input lri_reg_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_reg(idx, value);
	endtask

	task automatic send_frame(input logic signed [15:0] s0, input logic signed [15:0] s1,
		input logic last, input bit closing);
		int gap;
		in_bus.valid      <= 1'b1;
		in_bus.sample_ch0 <= s0;
		in_bus.sample_ch1 <= s1;
		in_bus.last_frame <= last;
		do @(posedge clk); while (!in_bus.ready);
		tracker.take_frame(s0, s1, last);
		if (closing) begin
			in_bus.valid <= 1'b0;
		end else if (gaps_on && burst_left == 0) begin
			in_bus.valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end else if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	task automatic drain();
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_random_phase(input int items);
		int stream_left;
		logic last;
		stream_left = $urandom_range(1, 16);
		for (int i = 0; i < items; i++) begin
			stream_left--;
			last = (stream_left == 0) || ($urandom_range(0, 19) == 0);
			if (last)
				stream_left = $urandom_range(1, 16);
			send_frame(pick_sample(), pick_sample(), last, i == items - 1);
		end
	endtask

	initial begin : output_side
		int hold_left;
		int pattern_age;
		logic [7:0] pattern;
		hold_left     = 0;
		pattern_age   = 0;
		pattern       = 8'hFF;
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_bus.valid && out_bus.ready)
				tracker.match_output(out_bus.out_ch0, out_bus.out_ch1, out_bus.run_end);
			if (pressure_armed) begin
				pressure_armed = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (pattern_age == 0) begin
				pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
				if (pattern == 8'h00)
					pattern = 8'h01;
				pattern_age = $urandom_range(16, 96);
			end else begin
				pattern_age--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else begin
				out_bus.ready <= pattern[0];
				pattern = {pattern[0], pattern[7:1]};
			end
		end
	end

	initial begin : run_limit
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [STEP_W-1:0] step_val;
		logic [CHAN_W-1:0] chan_val;
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		in_bus.valid      <= 1'b0;
		in_bus.sample_ch0 <= '0;
		in_bus.sample_ch1 <= '0;
		in_bus.last_frame <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default rate: extremes, then a stream of one frame
		send_frame(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
		send_frame(16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
		send_frame(16'sh0000, 16'shFFFF, 1'b0, 1'b0);
		send_frame(16'shFFFF, 16'sh0000, 1'b1, 1'b0);
		send_frame(16'sh3039, 16'shCFC7, 1'b1, 1'b1);
		drain();

		// step below the floor in mono: full result count on the final frame
		write_reg(REG_STEP_RATIO, 32'd0);
		write_reg(REG_CHANNEL_COUNT, 32'd1);
		send_frame(16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
		send_frame(16'sh7FFF, 16'sh8000, 1'b1, 1'b1);
		drain();

		// largest step: frames without output
		write_reg(REG_STEP_RATIO, 32'h001F_FFFF);
		write_reg(REG_CHANNEL_COUNT, 32'd0);
		send_frame(16'sh1234, 16'shEDCB, 1'b0, 1'b0);
		send_frame(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
		send_frame(16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
		send_frame(16'sh5555, 16'shAAAA, 1'b1, 1'b1);
		drain();

		write_reg(REG_STEP_RATIO, 32'd2048);
		write_reg(REG_CHANNEL_COUNT, 32'd3);
		send_frame(16'sh0001, 16'shFFFF, 1'b0, 1'b0);
		send_frame(16'sh8000, 16'sh8000, 1'b0, 1'b0);
		send_frame(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1);
		drain();

		write_reg(REG_STEP_RATIO, 32'd98304);
		write_reg(REG_CHANNEL_COUNT, 32'd2);
		send_frame(16'sh4000, 16'shC000, 1'b0, 1'b0);
		send_frame(16'shC000, 16'sh4000, 1'b0, 1'b0);
		send_frame(16'sh7FFF, 16'sh0001, 1'b0, 1'b0);
		send_frame(16'sh8001, 16'shFFFE, 1'b0, 1'b0);
		send_frame(16'sh0000, 16'sh0000, 1'b1, 1'b1);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 9))
				0: step_val = STEP_MIN;
				1: step_val = 21'h1FFFFF;
				2: step_val = STEP_W'($urandom_range(0, 2047));
				3: step_val = STEP_W'(1572864);
				default: step_val = STEP_W'($urandom_range(16384, 262144));
			endcase
			chan_val = CHAN_W'($urandom_range(0, 3));
			gaps_on  = ($urandom_range(0, 3) != 0);
			if (p == PRESSURE_PHASE) begin
				step_val = STEP_W'(32768);
				gaps_on  = 1'b0;
			end
			write_reg(REG_STEP_RATIO, ($urandom & 32'hFFE0_0000) | 32'(step_val));
			write_reg(REG_CHANNEL_COUNT, ($urandom & 32'hFFFF_FFFC) | 32'(chan_val));
			if (p == PRESSURE_PHASE)
				pressure_armed = 1'b1;
			run_random_phase(RANDOM_ITEMS);
			drain();
		end

		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
